@@ hdl/l1vl2_pkg.sv @@
// ----------------------------------------------------------------------------
// l1vl2_pkg
// Types and fixed constants shared by the L1 / victim / L2 load hierarchy.
// ----------------------------------------------------------------------------
package l1vl2_pkg;

	localparam int L1_LINES     = 16;
	localparam int L2_SET_COUNT = 16;
	localparam int IDX_W        = 4;
	localparam int TAG_W        = 26;
	localparam int VTAG_W       = 30;
	localparam int WORD_W       = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [2:0] OUT_IGNORED = 3'd0;
	localparam logic [2:0] OUT_L1_HIT  = 3'd1;
	localparam logic [2:0] OUT_VIC_HIT = 3'd2;
	localparam logic [2:0] OUT_L2_HIT  = 3'd3;
	localparam logic [2:0] OUT_FILL    = 3'd4;

	typedef struct packed {
		logic              is_read;
		logic [31:0]       address;
		logic [WORD_W-1:0] mem_word;
	} req_t;

	typedef struct packed {
		logic [2:0]        outcome;
		logic [WORD_W-1:0] line_data;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_LOOK = 3'b001,
		ST_CHK  = 3'b010,
		ST_INS  = 3'b100
	} state_t;

endpackage

@@ hdl/l1vl2_ram.sv @@
// ----------------------------------------------------------------------------
// l1vl2_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module l1vl2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/l1vl2_front.sv @@
// ----------------------------------------------------------------------------
// l1vl2_front
// Accepts access beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module l1vl2_front
	import l1vl2_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic q_valid,
	output req_t q_item,
	input  logic q_ready
);

	req_t       slot_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (count_q == 2'(QUEUE_DEPTH));
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = q_ready && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= request;
		end
	end

endmodule

@@ hdl/l1vl2_back.sv @@
// ----------------------------------------------------------------------------
// l1vl2_back
// Carries out one access: L1 and victim lookup, L2 read, victim push-out.
// ----------------------------------------------------------------------------
module l1vl2_back
	import l1vl2_pkg::*;
#(
	parameter int L2_WAY_COUNT   = 8,
	parameter int VICTIM_ENTRIES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  req_t q_item,
	output logic q_ready,
	output logic empty,
	input  logic pop,
	output rsp_t result
);

	localparam int VA    = $clog2(VICTIM_ENTRIES);
	localparam int WA    = $clog2(L2_WAY_COUNT);
	localparam int WAY_W = TAG_W + WORD_W;
	localparam int ROW_W = L2_WAY_COUNT * WAY_W;

	logic              l1_valid_q [L1_LINES];
	logic [TAG_W-1:0]  l1_tag_q   [L1_LINES];
	logic [WORD_W-1:0] l1_word_q  [L1_LINES];
	logic              vic_valid_q [VICTIM_ENTRIES];
	logic [VTAG_W-1:0] vic_tag_q   [VICTIM_ENTRIES];
	logic [WORD_W-1:0] vic_word_q  [VICTIM_ENTRIES];
	logic [VA-1:0]     vic_age_q   [VICTIM_ENTRIES];
	logic              l2_valid_q [L2_SET_COUNT][L2_WAY_COUNT];
	logic [WA-1:0]     l2_age_q   [L2_SET_COUNT][L2_WAY_COUNT];

	state_t            state_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic [TAG_W-1:0]  cur_tag_q;
	logic [WORD_W-1:0] cur_mem_q;
	logic [IDX_W-1:0]  ins_set_q;
	logic [TAG_W-1:0]  ins_tag_q;
	logic [WORD_W-1:0] ins_word_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              out_free;
	logic [IDX_W-1:0]  idx;
	logic [TAG_W-1:0]  tag;
	logic [VTAG_W-1:0] vtag;
	logic              l1_hit;
	logic              vhit;
	logic [VA-1:0]     vhit_idx;
	logic [VA-1:0]     vpick;
	logic [ROW_W-1:0]  row;
	logic              l2hit;
	logic [WA-1:0]     l2way;
	logic [WA-1:0]     ipick;
	logic [ROW_W-1:0]  new_row;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic              ram_we;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign q_ready  = (state_q == ST_LOOK) && out_free;

	assign idx  = q_item.address[5:2];
	assign tag  = q_item.address[31:6];
	assign vtag = q_item.address[31:2];

	always_comb begin
		l1_hit   = l1_valid_q[idx] && (l1_tag_q[idx] == tag);
		vhit     = 1'b0;
		vhit_idx = '0;
		vpick    = '0;
		for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
			if (vic_valid_q[i] && vic_tag_q[i] == vtag) begin
				vhit     = 1'b1;
				vhit_idx = VA'(i);
			end
			if (vic_age_q[i] == '0) begin
				vpick = VA'(i);
			end
		end
	end

	always_comb begin
		l2hit = 1'b0;
		l2way = '0;
		ipick = '0;
		for (int w = L2_WAY_COUNT - 1; w >= 0; w--) begin
			if (l2_valid_q[cur_idx_q][w] && row[w*WAY_W+WORD_W +: TAG_W] == cur_tag_q) begin
				l2hit = 1'b1;
				l2way = WA'(w);
			end
			if (l2_age_q[ins_set_q][w] == '0) begin
				ipick = WA'(w);
			end
		end
		new_row = row;
		new_row[ipick*WAY_W +: WAY_W] = {ins_tag_q, ins_word_q};
	end

	// read the access set on lookup, the push-out set on leaving the check
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx;
		unique case (state_q)
			ST_LOOK: begin
				ram_re    = q_valid && out_free && q_item.is_read && !l1_hit && !vhit;
				ram_raddr = idx;
			end
			ST_CHK: begin
				ram_re    = out_free;
				ram_raddr = vic_tag_q[vpick][IDX_W-1:0];
			end
			ST_INS: begin
				ram_re    = 1'b0;
				ram_raddr = ins_set_q;
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = idx;
			end
		endcase
	end

	assign ram_we = (state_q == ST_INS);

	l1vl2_ram #(
		.WIDTH(ROW_W),
		.DEPTH(L2_SET_COUNT)
	) u_l2_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ins_set_q),
		.wdata(new_row),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOOK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cur_idx_q   <= '0;
			cur_tag_q   <= '0;
			cur_mem_q   <= '0;
			ins_set_q   <= '0;
			ins_tag_q   <= '0;
			ins_word_q  <= '0;
			for (int l = 0; l < L1_LINES; l++) begin
				l1_valid_q[l] <= 1'b0;
				l1_tag_q[l]   <= '0;
				l1_word_q[l]  <= '0;
			end
			for (int i = 0; i < VICTIM_ENTRIES; i++) begin
				vic_valid_q[i] <= 1'b0;
				vic_tag_q[i]   <= '0;
				vic_word_q[i]  <= '0;
				vic_age_q[i]   <= VA'(i);
			end
			for (int s = 0; s < L2_SET_COUNT; s++) begin
				for (int w = 0; w < L2_WAY_COUNT; w++) begin
					l2_valid_q[s][w] <= 1'b0;
					l2_age_q[s][w]   <= WA'(w);
				end
			end
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOOK: begin
					if (q_valid && out_free) begin
						cur_idx_q <= idx;
						cur_tag_q <= tag;
						cur_mem_q <= q_item.mem_word;
						priority if (!q_item.is_read) begin
							out_valid_q <= 1'b1;
							out_q       <= '{OUT_IGNORED, '0};
						end else if (l1_hit) begin
							out_valid_q <= 1'b1;
							out_q       <= '{OUT_L1_HIT, l1_word_q[idx]};
						end else if (vhit) begin
							// swap the victim line with the L1 line
							if (l1_valid_q[idx]) begin
								vic_tag_q[vhit_idx]  <= {l1_tag_q[idx], idx};
								vic_word_q[vhit_idx] <= l1_word_q[idx];
							end else begin
								vic_valid_q[vhit_idx] <= 1'b0;
							end
							for (int i = 0; i < VICTIM_ENTRIES; i++) begin
								if (vic_age_q[i] > vic_age_q[vhit_idx]) begin
									vic_age_q[i] <= vic_age_q[i] - VA'(1);
								end
							end
							vic_age_q[vhit_idx] <= VA'(VICTIM_ENTRIES - 1);
							l1_word_q[idx]  <= vic_word_q[vhit_idx];
							l1_tag_q[idx]   <= tag;
							l1_valid_q[idx] <= 1'b1;
							out_valid_q     <= 1'b1;
							out_q           <= '{OUT_VIC_HIT, vic_word_q[vhit_idx]};
						end else begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (l2hit) begin
							l2_valid_q[cur_idx_q][l2way] <= 1'b0;
							l1_word_q[cur_idx_q]         <= row[l2way*WAY_W +: WORD_W];
							out_q <= '{OUT_L2_HIT, row[l2way*WAY_W +: WORD_W]};
						end else begin
							l1_word_q[cur_idx_q] <= cur_mem_q;
							out_q                <= '{OUT_FILL, cur_mem_q};
						end
						l1_tag_q[cur_idx_q]   <= cur_tag_q;
						l1_valid_q[cur_idx_q] <= 1'b1;
						state_q               <= ST_LOOK;
						// push the displaced L1 line into the oldest victim slot
						if (l1_valid_q[cur_idx_q]) begin
							for (int i = 0; i < VICTIM_ENTRIES; i++) begin
								if (vic_age_q[i] != '0) begin
									vic_age_q[i] <= vic_age_q[i] - VA'(1);
								end
							end
							vic_age_q[vpick]   <= VA'(VICTIM_ENTRIES - 1);
							vic_tag_q[vpick]   <= {l1_tag_q[cur_idx_q], cur_idx_q};
							vic_word_q[vpick]  <= l1_word_q[cur_idx_q];
							vic_valid_q[vpick] <= 1'b1;
							ins_set_q  <= vic_tag_q[vpick][IDX_W-1:0];
							ins_tag_q  <= vic_tag_q[vpick][VTAG_W-1:IDX_W];
							ins_word_q <= vic_word_q[vpick];
							if (vic_valid_q[vpick]) begin
								state_q <= ST_INS;
							end
						end
					end
				end
				ST_INS: begin
					for (int w = 0; w < L2_WAY_COUNT; w++) begin
						if (l2_age_q[ins_set_q][w] != '0) begin
							l2_age_q[ins_set_q][w] <= l2_age_q[ins_set_q][w] - WA'(1);
						end
					end
					l2_age_q[ins_set_q][ipick]   <= WA'(L2_WAY_COUNT - 1);
					l2_valid_q[ins_set_q][ipick] <= 1'b1;
					state_q                      <= ST_LOOK;
				end
				default: begin
					state_q <= ST_LOOK;
				end
			endcase
		end
	end

endmodule

@@ hdl/l1_victim_l2_load_hierarchy_top.sv @@
// ----------------------------------------------------------------------------
// l1_victim_l2_load_hierarchy_top
// Exclusive load hierarchy: direct-mapped L1, LRU victim cache, LRU L2.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// request   push / full      req_t: is_read, address, mem_word
// result    empty / pop      rsp_t: outcome, line_data
//
// An L1 or victim hit, or an ignored beat, finishes in the back end's lookup
// state; an L2 access adds the check state (registered L2 set read) and,
// for a victim push-out, the insert state (read-modify-write of its L2 set).
// Reset clears all valid bits and sets LRU ages at once; no clearing pass.
// A two-beat queue decouples request from the back end; a held result
// stalls the back end, and the request side once the queue is full.
// ----------------------------------------------------------------------------
module l1_victim_l2_load_hierarchy_top
	import l1vl2_pkg::*;
#(
	parameter int L2_WAY_COUNT   = 8,
	parameter int VICTIM_ENTRIES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output rsp_t result
);

	logic q_valid;
	logic q_ready;
	req_t q_item;

	l1vl2_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_ready(q_ready)
	);

	l1vl2_back #(
		.L2_WAY_COUNT  (L2_WAY_COUNT),
		.VICTIM_ENTRIES(VICTIM_ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_ready(q_ready),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
